/* rtl/core/fv_pkg.sv */
`timescale 1ns / 1ps

package fv_pkg;

   // Verdict codes, first failing check wins
   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_LENGTH   = 3'd1,
      ERR_HEADER   = 3'd2,
      ERR_CHECKSUM = 3'd3,
      ERR_ADDRESS  = 3'd4
   } err_code_type;

   // Register slots, one per 8-byte step of the address
   typedef enum logic [1:0] {
      REG_HEADER_TO_NODE = 2'd0,
      REG_HEADER_TO_WIRE = 2'd1,
      REG_OWN_ADDRESS    = 2'd2,
      REG_BYPASS_CHECKS  = 2'd3
   } reg_index_type;

   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned ADDR_W   = 48;
   localparam int unsigned HDR_W    = 16;
   localparam int unsigned CODE_W   = 3;
   localparam int unsigned PADDR_W  = 5;
   localparam int unsigned PDATA_W  = 64;

   localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;
   localparam logic [COUNT_W-1:0] IDX_HDR_LO   = 16'd1;
   localparam logic [COUNT_W-1:0] IDX_ADDR_LO  = 16'd2;
   localparam logic [COUNT_W-1:0] IDX_ADDR_END = 16'd8;
   localparam logic [COUNT_W-1:0] IDX_LEN_HI   = 16'd8;
   localparam logic [COUNT_W-1:0] IDX_LEN_LO   = 16'd9;
   localparam logic [COUNT_W-1:0] MIN_FRAME    = 16'd3;

   localparam logic MODE_TO_NODE = 1'b0;

endpackage

/* rtl/core/fv_channels.sv */
`timescale 1ns / 1ps

interface fv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   logic       mode;

   modport source (output valid, output data_byte, output last_byte, output mode,
                   input ready);
   modport sink   (input valid, input data_byte, input last_byte, input mode,
                   output ready);
endinterface

interface fv_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_ok;
   logic [2:0]  error_code;
   logic [15:0] frame_length;

   modport source (output valid, output frame_ok, output error_code,
                   output frame_length, input ready);
   modport sink   (input valid, input frame_ok, input error_code,
                   input frame_length, output ready);
endinterface

/* rtl/core/frame_validator.sv */
`timescale 1ns / 1ps

// Frame validator: takes a frame one byte per request (last_byte marks the end,
// mode is taken from the first byte) and returns one verdict per frame on the
// response channel: frame_ok, an error code (length, header, checksum, address,
// first failure wins) and the saturated byte count. Sustained rate is one byte
// per clock while the response side keeps up; each request passes through the
// input register, and a last byte's verdict is loaded from there into the
// response register. Only a last byte waits for the response register; other
// bytes never stall in the input register. Registers sit on an APB-style port
// at byte addresses 0 (header to node), 8 (header to wire), 16 (own address,
// frame byte 2 in bits 47:40) and 24 (bypass checks); write them only while
// no frame is in flight.

module frame_validator (
   input  logic                            clock,
   input  logic                            reset,
   fv_req_if.sink                          req_if,
   fv_rsp_if.source                        rsp_if,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fv_pkg::PADDR_W-1:0]      paddr,
   input  logic [fv_pkg::PDATA_W-1:0]      pwdata,
   output logic [fv_pkg::PDATA_W-1:0]      prdata,
   output logic                            pready
);

   // ---------------------------------------------------------------- config
   logic [fv_pkg::HDR_W-1:0]  hdr_node_ff;
   logic [fv_pkg::HDR_W-1:0]  hdr_wire_ff;
   logic [fv_pkg::ADDR_W-1:0] own_addr_ff;
   logic                      bypass_ff;
   logic                      csr_write;
   fv_pkg::reg_index_type     csr_sel;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   // decode on the 8-byte register slot only
   assign csr_sel   = fv_pkg::reg_index_type'(paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_node_ff <= '0;
         hdr_wire_ff <= '0;
         own_addr_ff <= '0;
         bypass_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_sel)
            fv_pkg::REG_HEADER_TO_NODE: hdr_node_ff <= pwdata[fv_pkg::HDR_W-1:0];
            fv_pkg::REG_HEADER_TO_WIRE: hdr_wire_ff <= pwdata[fv_pkg::HDR_W-1:0];
            fv_pkg::REG_OWN_ADDRESS:    own_addr_ff <= pwdata[fv_pkg::ADDR_W-1:0];
            fv_pkg::REG_BYPASS_CHECKS:  bypass_ff   <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_sel)
         fv_pkg::REG_HEADER_TO_NODE: prdata = {48'd0, hdr_node_ff};
         fv_pkg::REG_HEADER_TO_WIRE: prdata = {48'd0, hdr_wire_ff};
         fv_pkg::REG_OWN_ADDRESS:    prdata = {16'd0, own_addr_ff};
         fv_pkg::REG_BYPASS_CHECKS:  prdata = {63'd0, bypass_ff};
         default:                    prdata = '0;
      endcase
   end

   // --------------------------------------------------------- input register
   logic                      in_valid_ff;
   logic [fv_pkg::BYTE_W-1:0] in_byte_ff;
   logic                      in_last_ff;
   logic                      in_mode_ff;
   logic                      advance;
   logic                      req_take;

   // Bytes without the end mark always advance; a last byte needs the response
   // register free or being drained this cycle.
   assign advance  = in_valid_ff && (!in_last_ff || !rsp_if.valid || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_take = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_if.data_byte;
         in_last_ff <= req_if.last_byte;
         in_mode_ff <= req_if.mode;
      end
   end

   // ------------------------------------------------------------ frame state
   logic [fv_pkg::COUNT_W-1:0] count_ff,    count_in;
   logic [fv_pkg::BYTE_W-1:0]  sum_ff,      sum_in;
   logic [fv_pkg::BYTE_W-1:0]  prev_ff,     prev_in;
   logic [fv_pkg::HDR_W-1:0]   hdr_seen_ff, hdr_seen_in;
   logic [fv_pkg::COUNT_W-1:0] len_fld_ff,  len_fld_in;
   logic                       addr_ok_ff,  addr_ok_in;
   logic                       mode_ff,     mode_in;

   // Values after this byte lands; the verdict looks at these
   logic [fv_pkg::COUNT_W-1:0] count_sat;
   logic [fv_pkg::HDR_W-1:0]   hdr_upd;
   logic [fv_pkg::COUNT_W-1:0] len_upd;
   logic                       addr_ok_upd;
   logic                       mode_upd;
   logic                       is_addr_byte;
   logic [fv_pkg::BYTE_W-1:0]  addr_want;
   logic [fv_pkg::HDR_W-1:0]   hdr_expect;
   fv_pkg::err_code_type       verdict;

   assign count_sat = (count_ff == fv_pkg::COUNT_MAX) ? fv_pkg::COUNT_MAX
                                                     : count_ff + 16'd1;
   assign mode_upd  = (count_ff == '0) ? in_mode_ff : mode_ff;

   assign is_addr_byte = (count_ff >= fv_pkg::IDX_ADDR_LO) &&
                         (count_ff <  fv_pkg::IDX_ADDR_END);

   // Pick the address byte expected at this position, byte 2 first
   always_comb begin
      addr_want = '0;
      unique case (count_ff[2:0])
         3'd2:    addr_want = own_addr_ff[47:40];
         3'd3:    addr_want = own_addr_ff[39:32];
         3'd4:    addr_want = own_addr_ff[31:24];
         3'd5:    addr_want = own_addr_ff[23:16];
         3'd6:    addr_want = own_addr_ff[15:8];
         3'd7:    addr_want = own_addr_ff[7:0];
         default: addr_want = '0;
      endcase
   end

   assign addr_ok_upd = addr_ok_ff && !(is_addr_byte && (addr_want != in_byte_ff));

   always_comb begin
      hdr_upd = hdr_seen_ff;
      len_upd = len_fld_ff;
      if (count_ff == '0) begin
         hdr_upd[15:8] = in_byte_ff;
      end else if (count_ff == fv_pkg::IDX_HDR_LO) begin
         hdr_upd[7:0] = in_byte_ff;
      end else if (count_ff == fv_pkg::IDX_LEN_HI) begin
         len_upd[15:8] = in_byte_ff;
      end else if (count_ff == fv_pkg::IDX_LEN_LO) begin
         len_upd[7:0] = in_byte_ff;
      end
   end

   assign hdr_expect = (mode_upd == fv_pkg::MODE_TO_NODE) ? hdr_node_ff : hdr_wire_ff;

   // Checks in order; the first failing one sets the code. The checksum holds
   // when the byte before last equals the 8-bit sum of everything ahead of it.
   always_comb begin
      priority if (count_sat < fv_pkg::MIN_FRAME || len_upd != count_sat) begin
         verdict = fv_pkg::ERR_LENGTH;
      end else if (hdr_upd != hdr_expect) begin
         verdict = fv_pkg::ERR_HEADER;
      end else if (!bypass_ff && sum_ff != prev_ff) begin
         verdict = fv_pkg::ERR_CHECKSUM;
      end else if (!bypass_ff && mode_upd == fv_pkg::MODE_TO_NODE && !addr_ok_upd) begin
         verdict = fv_pkg::ERR_ADDRESS;
      end else begin
         verdict = fv_pkg::ERR_NONE;
      end
   end

   // Next frame state: a last byte returns everything to the idle values
   always_comb begin
      count_in    = count_ff;
      sum_in      = sum_ff;
      prev_in     = prev_ff;
      hdr_seen_in = hdr_seen_ff;
      len_fld_in  = len_fld_ff;
      addr_ok_in  = addr_ok_ff;
      mode_in     = mode_ff;
      if (advance) begin
         if (in_last_ff) begin
            count_in    = '0;
            sum_in      = '0;
            prev_in     = '0;
            hdr_seen_in = '0;
            len_fld_in  = '0;
            addr_ok_in  = 1'b1;
            mode_in     = 1'b0;
         end else begin
            count_in    = count_sat;
            // fold the previous byte into the sum, wrapping at 8 bits
            sum_in      = (count_ff == '0) ? sum_ff : sum_ff + prev_ff;
            prev_in     = in_byte_ff;
            hdr_seen_in = hdr_upd;
            len_fld_in  = len_upd;
            addr_ok_in  = addr_ok_upd;
            mode_in     = mode_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         sum_ff      <= '0;
         prev_ff     <= '0;
         hdr_seen_ff <= '0;
         len_fld_ff  <= '0;
         addr_ok_ff  <= 1'b1;
         mode_ff     <= 1'b0;
      end else begin
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         prev_ff     <= prev_in;
         hdr_seen_ff <= hdr_seen_in;
         len_fld_ff  <= len_fld_in;
         addr_ok_ff  <= addr_ok_in;
         mode_ff     <= mode_in;
      end
   end

   // ------------------------------------------------------- response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_ok_ff;
   fv_pkg::err_code_type       rsp_code_ff;
   logic [fv_pkg::COUNT_W-1:0] rsp_len_ff;
   logic                       rsp_load;

   assign rsp_load     = advance && in_last_ff;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ok_ff   <= (verdict == fv_pkg::ERR_NONE);
         rsp_code_ff <= verdict;
         rsp_len_ff  <= count_sat;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.frame_ok     = rsp_ok_ff;
   assign rsp_if.error_code   = rsp_code_ff;
   assign rsp_if.frame_length = rsp_len_ff;

   // -------------------------------------------------------------- assertions
   // a verdict appears only after a last byte was processed
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(rsp_load))
      else $error("response raised without a last byte");

   // frame_ok agrees with the error code
   a_ok_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ok_ff == (rsp_code_ff == fv_pkg::ERR_NONE)))
      else $error("frame_ok disagrees with error code");

   // a last byte leaves the frame state cleared
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (count_ff == '0 && addr_ok_ff && sum_ff == '0))
      else $error("frame state not cleared after last byte");

   // no address byte is checked before byte 2
   a_addr_early: assert property (@(posedge clock) disable iff (reset)
      (count_ff < fv_pkg::MIN_FRAME) |-> addr_ok_ff)
      else $error("address mismatch before any address byte");

   // the input side only stalls behind a blocked verdict
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_if.ready))
      else $error("request stalled without a blocked response");

endmodule

/* dv/tb_frame_validator.sv */
`timescale 1ns / 1ps

module tb_frame_validator;

   localparam logic MODE_TO_WIRE = ~fv_pkg::MODE_TO_NODE;
   localparam int   MAX_GAP      = 11;
   localparam int   HOLD_CYCLES  = 250;
   localparam int   STALL_LIMIT  = 4000;
   localparam int   RANDOM_BUDGET = 340;
   localparam int   LONG_FRAME    = 300;

   typedef struct packed {
      logic                 ok;
      fv_pkg::err_code_type code;
      logic [15:0]          length;
   } verdict_type;

   logic clock = 1'b0;
   logic reset;

   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [fv_pkg::PADDR_W-1:0]  paddr;
   logic [fv_pkg::PDATA_W-1:0]  pwdata;
   logic [fv_pkg::PDATA_W-1:0]  prdata;
   logic                        pready;

   fv_req_if req_ch ();
   fv_rsp_if rsp_ch ();

   frame_validator i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_ch),
      .rsp_if  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #6 clock = ~clock;

   // Register copies, updated at each write
   logic [15:0] set_hdr_node;
   logic [15:0] set_hdr_wire;
   logic [47:0] set_address;
   logic        set_bypass;

   // Per-frame tracking state
   logic [15:0] frm_count;
   logic [7:0]  frm_sum;
   logic [7:0]  frm_prev;
   logic [15:0] frm_header;
   logic [15:0] frm_length;
   logic        frm_addr_ok;
   logic        frm_mode;

   verdict_type pending_verdicts[$];
   logic [7:0]  frame_buf[$];

   int  mismatches = 0;
   int  bytes_sent = 0;
   int  longest_frame = 0;
   int  settings_applied = 0;
   int  code_hits[0:4] = '{default: 0};
   int  stall_cycles = 0;
   int  rx_hold_req = 0;
   bit  idle_on = 1'b1;
   bit  reset_done = 1'b0;

   function automatic void report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH @%0t: %s", $time, msg);
   endfunction

   function automatic void clear_frame();
      frm_count   = '0;
      frm_sum     = '0;
      frm_prev    = '0;
      frm_header  = '0;
      frm_length  = '0;
      frm_addr_ok = 1'b1;
      frm_mode    = fv_pkg::MODE_TO_NODE;
   endfunction

   // Advance the frame state by one accepted byte; queue a verdict on the last one
   function automatic void track_byte(input logic [7:0] b, input logic last, input logic m);
      logic [15:0] idx;
      logic [15:0] count;
      logic [15:0] want_hdr;
      verdict_type v;
      idx = frm_count;
      if (idx == 16'd0) begin
         frm_mode = m;
         frm_header[15:8] = b;
      end else if (idx == fv_pkg::IDX_HDR_LO) begin
         frm_header[7:0] = b;
      end else if (idx >= fv_pkg::IDX_ADDR_LO && idx < fv_pkg::IDX_ADDR_END) begin
         if (set_address[8 * (7 - int'(idx)) +: 8] != b) frm_addr_ok = 1'b0;
      end else if (idx == fv_pkg::IDX_LEN_HI) begin
         frm_length[15:8] = b;
      end else if (idx == fv_pkg::IDX_LEN_LO) begin
         frm_length[7:0] = b;
      end
      count = (idx == fv_pkg::COUNT_MAX) ? idx : idx + 16'd1;
      if (!last) begin
         if (idx != 16'd0) frm_sum = frm_sum + frm_prev;
         frm_prev  = b;
         frm_count = count;
         return;
      end
      want_hdr = (frm_mode == fv_pkg::MODE_TO_NODE) ? set_hdr_node : set_hdr_wire;
      if (count < fv_pkg::MIN_FRAME || frm_length != count)
         v.code = fv_pkg::ERR_LENGTH;
      else if (frm_header != want_hdr)
         v.code = fv_pkg::ERR_HEADER;
      else if (!set_bypass && frm_sum != frm_prev)
         v.code = fv_pkg::ERR_CHECKSUM;
      else if (!set_bypass && frm_mode == fv_pkg::MODE_TO_NODE && !frm_addr_ok)
         v.code = fv_pkg::ERR_ADDRESS;
      else
         v.code = fv_pkg::ERR_NONE;
      v.ok     = (v.code == fv_pkg::ERR_NONE);
      v.length = count;
      pending_verdicts.push_back(v);
      clear_frame();
   endfunction

   // Fill frame_buf: n >= 12 (10 to wire) passes every check for current settings
   function automatic void build_frame(input int n, input logic m);
      logic [15:0] hdr;
      logic [15:0] len;
      logic [7:0]  sum;
      int          chk;
      frame_buf.delete();
      hdr = (m == fv_pkg::MODE_TO_NODE) ? set_hdr_node : set_hdr_wire;
      len = (n > 65535) ? 16'hFFFF : n[15:0];
      for (int i = 0; i < n; i++) begin
         if (i == 0)      frame_buf.push_back(hdr[15:8]);
         else if (i == 1) frame_buf.push_back(hdr[7:0]);
         else if (i < 8)  frame_buf.push_back(set_address[8 * (7 - i) +: 8]);
         else if (i == 8) frame_buf.push_back(len[15:8]);
         else if (i == 9) frame_buf.push_back(len[7:0]);
         else             frame_buf.push_back(8'($urandom));
      end
      chk = n - 2;
      sum = '0;
      if (chk >= 10) begin
         for (int i = 0; i < chk; i++) sum = sum + frame_buf[i];
         frame_buf[chk] = sum;
      end else if (chk >= 8 && m != fv_pkg::MODE_TO_NODE) begin
         // checksum byte lands on the length field: balance it with byte 7
         for (int i = 0; i < chk; i++) if (i != 7) sum = sum + frame_buf[i];
         frame_buf[7] = frame_buf[chk] - sum;
      end
   endfunction

   function automatic void spoil_frame();
      int idx;
      case ($urandom_range(0, 3))
         0: begin
            idx = $urandom_range(0, frame_buf.size() - 1);
            frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
         end
         1: if (frame_buf.size() > 1) void'(frame_buf.pop_back());
         2: frame_buf.push_back(8'($urandom));
         default: begin
            idx = $urandom_range(0, (frame_buf.size() < 10) ? frame_buf.size() - 1 : 9);
            frame_buf[idx] = frame_buf[idx] ^ (8'd1 << $urandom_range(0, 7));
         end
      endcase
   endfunction

   // Offer one request after a random gap and hold it until accepted
   task automatic send_byte(input logic [7:0] b, input logic last, input logic m);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= last;
      req_ch.mode      <= m;
      do @(posedge clock); while (!req_ch.ready);
      track_byte(b, last, m);
      bytes_sent++;
   endtask

   // Mode matters only on byte 0; randomize it elsewhere
   task automatic send_frame(input logic m);
      int n;
      n = frame_buf.size();
      if (n > longest_frame) longest_frame = n;
      for (int i = 0; i < n; i++)
         send_byte(frame_buf[i], i == n - 1, (i == 0) ? m : logic'($urandom_range(0, 1)));
   endtask

   task automatic wait_verdicts_drained();
      req_ch.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      // a trailing byte may still sit in the input stage
      repeat (4) @(posedge clock);
   endtask

   // Write one register, read it back, and mirror it into the predictor
   task automatic write_reg(input fv_pkg::reg_index_type idx, input logic [63:0] value);
      logic [63:0] mask;
      case (idx)
         fv_pkg::REG_HEADER_TO_NODE: begin
            mask = 64'hFFFF;
            set_hdr_node = value[15:0];
         end
         fv_pkg::REG_HEADER_TO_WIRE: begin
            mask = 64'hFFFF;
            set_hdr_wire = value[15:0];
         end
         fv_pkg::REG_OWN_ADDRESS: begin
            mask = 64'hFFFF_FFFF_FFFF;
            set_address = value[47:0];
         end
         default: begin
            mask = 64'h1;
            set_bypass = value[0];
         end
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if ((prdata & mask) !== (value & mask))
         report_mismatch($sformatf("register %s read back %h, expected %h",
                                   idx.name(), prdata & mask, value & mask));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic apply_settings(input logic [15:0] hdr_node, input logic [15:0] hdr_wire,
                                 input logic [47:0] address, input logic bypass);
      write_reg(fv_pkg::REG_HEADER_TO_NODE, {48'd0, hdr_node});
      write_reg(fv_pkg::REG_HEADER_TO_WIRE, {48'd0, hdr_wire});
      write_reg(fv_pkg::REG_OWN_ADDRESS, {16'd0, address});
      write_reg(fv_pkg::REG_BYPASS_CHECKS, {63'd0, bypass});
      settings_applied++;
   endtask

   // One-, two- and three-byte frames: always a length error
   task automatic test_short_frames();
      send_byte(8'hFF, 1'b1, MODE_TO_WIRE);
      send_byte(8'h00, 1'b1, fv_pkg::MODE_TO_NODE);
      send_byte(8'h5A, 1'b0, MODE_TO_WIRE);
      send_byte(8'hA5, 1'b1, fv_pkg::MODE_TO_NODE);
      build_frame(3, fv_pkg::MODE_TO_NODE);
      send_frame(fv_pkg::MODE_TO_NODE);
      wait_verdicts_drained();
   endtask

   // Smallest passing frame in each direction
   task automatic test_clean_frames();
      build_frame(10, MODE_TO_WIRE);
      send_frame(MODE_TO_WIRE);
      build_frame(12, fv_pkg::MODE_TO_NODE);
      send_frame(fv_pkg::MODE_TO_NODE);
      wait_verdicts_drained();
   endtask

   // Stall the verdict side while frames keep coming, then let everything drain
   task automatic test_backpressure();
      logic m;
      idle_on = 1'b0;
      rx_hold_req = HOLD_CYCLES;
      for (int k = 0; k < 12; k++) begin
         m = logic'($urandom_range(0, 1));
         build_frame((k % 3 == 0) ? 12 : $urandom_range(3, 6), m);
         send_frame(m);
      end
      wait_verdicts_drained();
      idle_on = 1'b1;
   endtask

   task automatic test_random_frames(input logic [15:0] hdr_node, input logic [15:0] hdr_wire,
                                     input logic [47:0] address, input logic bypass,
                                     input int budget);
      int   start;
      int   n;
      int   pick;
      logic m;
      apply_settings(hdr_node, hdr_wire, address, bypass);
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         if ($urandom_range(0, 9) == 0) idle_on = !idle_on;
         pick = $urandom_range(0, 99);
         m = logic'($urandom_range(0, 1));
         if (pick < 80) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 300) : $urandom_range(10, 28);
            build_frame(n, m);
            if (pick >= 55) spoil_frame();
            // send with the other direction's header in place
            if (pick >= 72) m = !m;
            send_frame(m);
         end else begin
            frame_buf.delete();
            n = $urandom_range(1, 14);
            for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom));
            send_frame(m);
         end
      end
      wait_verdicts_drained();
      idle_on = 1'b1;
   endtask

   // A clean frame well past 255 bytes, so both length bytes and a long sum count
   task automatic test_long_frame();
      idle_on = 1'b0;
      build_frame(LONG_FRAME, fv_pkg::MODE_TO_NODE);
      send_frame(fv_pkg::MODE_TO_NODE);
      wait_verdicts_drained();
      idle_on = 1'b1;
   endtask

   // Verdict side: random ready gaps, one long hold on request, compare in order
   initial begin : verdict_sink
      int          pause;
      verdict_type want;
      while (!reset_done) @(posedge clock);
      forever begin
         if (rx_hold_req > 0) begin
            pause = rx_hold_req;
            rx_hold_req = 0;
         end else begin
            pause = idle_on ? $urandom_range(0, MAX_GAP) : 0;
         end
         if (pause > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("verdict with none expected: ok=%0d code=%0d len=%0d",
                                      rsp_ch.frame_ok, rsp_ch.error_code, rsp_ch.frame_length));
         end else begin
            want = pending_verdicts.pop_front();
            code_hits[int'(want.code)]++;
            if (rsp_ch.frame_ok !== want.ok || rsp_ch.error_code !== want.code ||
                rsp_ch.frame_length !== want.length)
               report_mismatch($sformatf(
                  "expected ok=%0d code=%0d len=%0d, got ok=%0d code=%0d len=%0d",
                  want.ok, want.code, want.length,
                  rsp_ch.frame_ok, rsp_ch.error_code, rsp_ch.frame_length));
         end
      end
   end

   // Drop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (psel && penable && pready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: %0d cycles without a handshake, %0d verdicts outstanding",
                  stall_cycles, pending_verdicts.size());
         $display("frame_validator regression: fail");
         $finish;
      end
   end

   initial begin
      reset            <= 1'b1;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.last_byte <= 1'b0;
      req_ch.mode      <= 1'b0;
      rsp_ch.ready     <= 1'b0;
      set_hdr_node = '0;
      set_hdr_wire = '0;
      set_address  = '0;
      set_bypass   = 1'b0;
      clear_frame();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      reset_done = 1'b1;

      apply_settings(16'hA55A, 16'h5AA5, {16'($urandom), $urandom}, 1'b0);
      test_short_frames();
      test_clean_frames();
      test_backpressure();
      test_random_frames(16'($urandom), 16'($urandom), {16'($urandom), $urandom}, 1'b0,
                         RANDOM_BUDGET);
      test_random_frames(16'hFFFF, 16'h0000, 48'hFFFF_FFFF_FFFF, 1'b1, RANDOM_BUDGET);
      test_random_frames(16'h0000, 16'hFFFF, 48'h0, 1'b0, RANDOM_BUDGET);
      test_random_frames(16'($urandom), 16'($urandom), {16'($urandom), $urandom}, 1'b1,
                         RANDOM_BUDGET);
      test_long_frame();

      wait_verdicts_drained();
      repeat (8) @(posedge clock);
      $display("covered %0d request bytes over %0d register settings, longest frame %0d bytes",
               bytes_sent, settings_applied, longest_frame);
      $display("verdicts: ok %0d, length %0d, header %0d, checksum %0d, address %0d",
               code_hits[0], code_hits[1], code_hits[2], code_hits[3], code_hits[4]);
      if (mismatches == 0 && pending_verdicts.size() == 0) begin
         $display("frame_validator regression: pass");
      end else begin
         $display("frame_validator regression: fail");
      end
      $finish;
   end

endmodule

/* frame_validator.f */
rtl/core/fv_pkg.sv
rtl/core/fv_channels.sv
rtl/core/frame_validator.sv
dv/tb_frame_validator.sv
